// File: rtl/swmf_pkg.sv
// Package with the shared constants and types of the running median filter.
`timescale 1ns / 1ps

package swmf_pkg;

  localparam int WINDOW_DEFAULT       = 10;
  localparam int SAMPLE_WIDTH_DEFAULT = 16;

  // Flags that one cell hands to its neighbours in the sorted row.
  typedef struct packed {
    logic le;       // Stored value is less than or equal to the incoming sample.
    logic ev_upto;  // The evicted entry sits in this cell or in one below it.
    logic le_c;     // After removal of the evicted entry, this slot stays below the sample.
  } cell_flags_t;

endpackage

// File: rtl/swmf_cell.sv
// One cell of the sorted window: a value, its age and the insert/evict logic.
`timescale 1ns / 1ps

module swmf_cell #(
  parameter int SAMPLE_WIDTH = swmf_pkg::SAMPLE_WIDTH_DEFAULT,
  parameter int WINDOW       = swmf_pkg::WINDOW_DEFAULT,
  parameter int AGE_W        = $clog2(WINDOW),
  parameter int RESET_AGE    = 0,
  parameter bit IS_FIRST     = 1'b0,
  parameter bit IS_LAST      = 1'b0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        shift,
  input  logic [SAMPLE_WIDTH-1:0]     sample,
  input  logic [SAMPLE_WIDTH-1:0]     lo_value,
  input  logic [AGE_W-1:0]            lo_age,
  input  swmf_pkg::cell_flags_t       lo_flags,
  input  logic [SAMPLE_WIDTH-1:0]     hi_value,
  input  logic [AGE_W-1:0]            hi_age,
  input  swmf_pkg::cell_flags_t       hi_flags,
  output logic [SAMPLE_WIDTH-1:0]     value,
  output logic [AGE_W-1:0]            age,
  output swmf_pkg::cell_flags_t       flags,
  output logic [SAMPLE_WIDTH-1:0]     value_next
);

  import swmf_pkg::*;

  localparam logic [AGE_W-1:0] AGE_LAST = AGE_W'(WINDOW - 1);

  logic                    evict;
  logic                    lo_ev_upto;
  logic                    lo_le_c;
  logic [SAMPLE_WIDTH-1:0] self_value;
  logic [AGE_W-1:0]        self_age;
  logic [SAMPLE_WIDTH-1:0] prev_value;
  logic [AGE_W-1:0]        prev_age;
  logic [AGE_W-1:0]        age_next;

  assign evict      = (age == AGE_LAST);
  assign lo_ev_upto = IS_FIRST ? 1'b0 : lo_flags.ev_upto;
  assign lo_le_c    = IS_FIRST ? 1'b0 : lo_flags.le_c;

  assign flags.le      = (value <= sample);
  assign flags.ev_upto = lo_ev_upto | evict;
  // The top slot of the compacted row does not exist, so it never stays below.
  assign flags.le_c    = IS_LAST ? 1'b0 : (flags.ev_upto ? hi_flags.le : flags.le);

  // Slot of the compacted row at this index, and at the index below.
  assign self_value = flags.ev_upto ? hi_value : value;
  assign self_age   = flags.ev_upto ? hi_age : age;
  assign prev_value = lo_ev_upto ? value : lo_value;
  assign prev_age   = lo_ev_upto ? age : lo_age;

  always_comb begin
    if (flags.le_c) begin
      value_next = self_value;
      age_next   = self_age + 1'b1;
    end else if (IS_FIRST || lo_le_c) begin
      value_next = sample;
      age_next   = '0;
    end else begin
      value_next = prev_value;
      age_next   = prev_age + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      age   <= AGE_W'(RESET_AGE);
    end else if (shift) begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule

// File: rtl/sliding_window_median_filter_core.sv
// Top level of the running median filter: the sorted cell row and the stream ports.
`timescale 1ns / 1ps
// Output: the median of a word is registered and shown in the cycle after its acceptance.
// Throughput: one word per cycle unless m_tready stalls; cells evict and insert on accept.
// Reset: synchronous and active high; the window reads as all zero and no result is pending.
// The rate is set by the combinational compare, evict and shift across the row of cells.

module sliding_window_median_filter_core #(
  parameter int WINDOW       = swmf_pkg::WINDOW_DEFAULT,
  parameter int SAMPLE_WIDTH = swmf_pkg::SAMPLE_WIDTH_DEFAULT,
  parameter int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // [SAMPLE_WIDTH-1:0] sample
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata    // [SAMPLE_WIDTH-1:0] median, zero above
);

  import swmf_pkg::*;

  localparam int AGE_W = $clog2(WINDOW);
  localparam int MID   = WINDOW / 2;

  // The cells keep the window in ascending order, each entry tagged with its age.
  // A new word evicts the entry whose age is WINDOW-1 and is inserted in order,
  // all in the cycle in which it is accepted.

  logic                    accept;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic [SAMPLE_WIDTH-1:0] median;

  logic [SAMPLE_WIDTH-1:0] cell_value      [WINDOW];
  logic [AGE_W-1:0]        cell_age        [WINDOW];
  cell_flags_t             cell_flags      [WINDOW];
  logic [SAMPLE_WIDTH-1:0] cell_value_next [WINDOW];

  // The output register frees the input side whenever it is empty or being emptied.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign sample   = s_tdata[SAMPLE_WIDTH-1:0];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    localparam int LO = (i == 0) ? 0 : i - 1;
    localparam int HI = (i == WINDOW - 1) ? WINDOW - 1 : i + 1;

    swmf_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .WINDOW       (WINDOW),
      .AGE_W        (AGE_W),
      .RESET_AGE    (i),
      .IS_FIRST     (i == 0),
      .IS_LAST      (i == WINDOW - 1)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (accept),
      .sample     (sample),
      .lo_value   (cell_value[LO]),
      .lo_age     (cell_age[LO]),
      .lo_flags   (cell_flags[LO]),
      .hi_value   (cell_value[HI]),
      .hi_age     (cell_age[HI]),
      .hi_flags   (cell_flags[HI]),
      .value      (cell_value[i]),
      .age        (cell_age[i]),
      .flags      (cell_flags[i]),
      .value_next (cell_value_next[i])
    );
  end

  // The median is the middle cell's value after the insertion.
  always_ff @(posedge clk) begin
    if (accept) begin
      median <= cell_value_next[MID];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = TDATA_W'(median);

endmodule
